/* hw/rtl/csvrpf_pkg.sv */
// Shared types, constants and codes for the CSV record parser with key fingerprint.
// Used by the controller, the datapath and the top level; depends on nothing else.
package csvrpf_pkg;

  // Sizing of the slot and of the name field
  localparam int SLOT_BITS      = 14;
  localparam int MAX_NAME_BYTES = 104;

  // Field widths
  localparam int TIME_W      = 27;
  localparam int DIFF_W      = TIME_W + 1;
  localparam int DIGIT_W     = 4;
  localparam int NAME_CNT_W  = 7;
  localparam int NUM_W       = 32;
  localparam int MONTH_W     = 4;
  localparam int HASH_SLOT_W = 14;
  localparam int WORD_W      = 64;
  localparam int HALF_W      = WORD_W / 2;
  localparam int BYTE_W      = 8;
  localparam int WIN_BYTES   = WORD_W / BYTE_W;
  localparam int TIME_DIGITS = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_BASE_UNITS = 1'b0;

  // Mixing constants
  localparam logic [WORD_W-1:0] GOLDEN_K = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_K    = 64'hFF51_AFD7_ED55_8CCD;
  localparam int MIX_SHIFT = 33;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

  // Calendar
  localparam int TICKS_PER_DAY = 86400 / 100;
  localparam int DAYS_IN_YEAR  = 365;
  localparam int MONTHS        = 12;
  localparam logic [TIME_W-1:0] YEAR_UNITS       = TIME_W'(TICKS_PER_DAY * DAYS_IN_YEAR);
  localparam logic [TIME_W-1:0] BASE_UNITS_RESET = TIME_W'(1798761600 / 100);
  localparam logic [8:0] MONTH_START [MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef enum logic [1:0] {PH_TIME, PH_NAME, PH_LEN, PH_STAMPS} phase_t;

  typedef enum logic [2:0] {
    MS_NONE, MS_A_LL, MS_A_LH, MS_A_HL, MS_MIX, MS_B_LL, MS_B_LH, MS_B_HL
  } mstep_t;

  typedef enum logic [3:0] {
    ST_RUN, ST_A_LL, ST_A_LH, ST_A_HL, ST_MIX, ST_B_LL, ST_B_LH, ST_B_HL, ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic   take_byte;
    logic   clear_line;
    mstep_t mstep;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic newline;
    logic last_field;
  } dp_status_t;

endpackage

/* hw/rtl/csvrpf_ctrl.sv */
// Controller state machine: accepts bytes, sequences the end-of-line multiply steps
// and owns the result valid flag. Depends on csvrpf_pkg.
module csvrpf_ctrl
  import csvrpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Hold state and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '{take_byte: 1'b0, clear_line: 1'b0, mstep: MS_NONE, load_out: 1'b0};
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_RUN: begin
        if (in_valid) begin
          if (status.newline) begin
            if (status.last_field) begin
              state_nxt = ST_A_LL;
            end else begin
              cmd.clear_line = 1'b1;
            end
          end else begin
            cmd.take_byte = 1'b1;
          end
        end
      end
      ST_A_LL: begin
        cmd.mstep = MS_A_LL;
        state_nxt = ST_A_LH;
      end
      ST_A_LH: begin
        cmd.mstep = MS_A_LH;
        state_nxt = ST_A_HL;
      end
      ST_A_HL: begin
        cmd.mstep = MS_A_HL;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mstep = MS_MIX;
        state_nxt = ST_B_LL;
      end
      ST_B_LL: begin
        cmd.mstep = MS_B_LL;
        state_nxt = ST_B_LH;
      end
      ST_B_LH: begin
        cmd.mstep = MS_B_LH;
        state_nxt = ST_B_HL;
      end
      ST_B_HL: begin
        cmd.mstep = MS_B_HL;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // load the result once the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.load_out   = 1'b1;
          cmd.clear_line = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_RUN);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/csvrpf_dp.sv */
// Datapath: line parser registers, shared 32x32 multiplier for the fingerprint,
// month lookup and result registers. Depends on csvrpf_pkg.
module csvrpf_dp
  import csvrpf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [TIME_W-1:0]      base_units,
  input  logic [BYTE_W-1:0]      in_text_byte,
  output logic [MONTH_W-1:0]     out_month_index,
  output logic                   out_in_year,
  output logic [NAME_CNT_W-1:0]  out_name_length,
  output logic [WORD_W-1:0]      out_first_bytes,
  output logic [WORD_W-1:0]      out_last_bytes,
  output logic [HASH_SLOT_W-1:0] out_hash_slot,
  output logic [NUM_W-1:0]       out_message_length,
  output logic [NUM_W-1:0]       out_stamp_count
);

  // Line state
  phase_t                           phase_r, phase_nxt;
  logic [DIGIT_W-1:0]               digit_r, digit_nxt;
  logic [TIME_W-1:0]                time_r, time_nxt;
  logic [NAME_CNT_W-1:0]            name_cnt_r, name_cnt_nxt;
  logic [WIN_BYTES-1:0][BYTE_W-1:0] head_r, head_nxt;
  logic [WORD_W-1:0]                tail_r, tail_nxt;
  logic [NUM_W-1:0]                 num_r, num_nxt;
  logic [NUM_W-1:0]                 len_r, len_nxt;

  // Fingerprint and calendar work registers
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] mix_r, mix_nxt;
  logic [DIFF_W-1:0] diff_r, diff_nxt;

  // Byte classification
  logic                is_comma;
  logic                is_digit;
  logic [DIGIT_W-1:0]  digit_val;
  logic [NUM_W+3:0]    dec_v;
  logic [NUM_W-1:0]    dec_sat;

  assign is_comma  = (in_text_byte == CH_COMMA);
  assign is_digit  = (in_text_byte >= CH_ZERO) && (in_text_byte <= CH_NINE);
  assign digit_val = is_digit ? DIGIT_W'(in_text_byte - CH_ZERO) : '0;

  assign status.newline    = (in_text_byte == CH_NEWLINE);
  assign status.last_field = (phase_r == PH_STAMPS);

  // Decimal step: num*10 + digit, saturate at the field width
  assign dec_v   = ({4'b0, num_r} << 3) + ({4'b0, num_r} << 1) + (NUM_W + 4)'(digit_val);
  assign dec_sat = (dec_v[NUM_W+3:NUM_W] != '0) ? '1 : dec_v[NUM_W-1:0];

  // Name windows as seen at end of line
  logic [WORD_W-1:0] first_w, last_w;
  assign first_w = head_r;
  assign last_w  = (name_cnt_r >= NAME_CNT_W'(WIN_BYTES)) ? tail_r : head_r;

  // Parse one byte per accepted transaction
  always_comb begin
    phase_nxt    = phase_r;
    digit_nxt    = digit_r;
    time_nxt     = time_r;
    name_cnt_nxt = name_cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    num_nxt      = num_r;
    len_nxt      = len_r;
    if (cmd.clear_line) begin
      phase_nxt    = PH_TIME;
      digit_nxt    = '0;
      time_nxt     = '0;
      name_cnt_nxt = '0;
      head_nxt     = '0;
      tail_nxt     = '0;
      num_nxt      = '0;
      len_nxt      = '0;
    end else if (cmd.take_byte) begin
      case (phase_r)
        PH_TIME: begin
          if (is_comma) begin
            phase_nxt = PH_NAME;
          end else begin
            if (digit_r < DIGIT_W'(TIME_DIGITS)) begin
              time_nxt = (time_r << 3) + (time_r << 1) + TIME_W'(digit_val);
            end
            if (digit_r != '1) begin
              digit_nxt = digit_r + 1'b1;
            end
          end
        end
        PH_NAME: begin
          if (is_comma) begin
            phase_nxt = PH_LEN;
            num_nxt   = '0;
          end else if (name_cnt_r < NAME_CNT_W'(MAX_NAME_BYTES)) begin
            if (name_cnt_r < NAME_CNT_W'(WIN_BYTES)) begin
              head_nxt[name_cnt_r[2:0]] = in_text_byte;
            end
            tail_nxt     = {in_text_byte, tail_r[WORD_W-1:BYTE_W]};
            name_cnt_nxt = name_cnt_r + 1'b1;
          end
        end
        PH_LEN: begin
          if (is_comma) begin
            len_nxt   = num_r;
            num_nxt   = '0;
            phase_nxt = PH_STAMPS;
          end else if (is_digit) begin
            num_nxt = dec_sat;
          end
        end
        PH_STAMPS: begin
          if (!is_comma && is_digit) begin
            num_nxt = dec_sat;
          end
        end
        default: begin
          phase_nxt = PH_TIME;
        end
      endcase
    end
  end

  // Shared multiplier: select one 32x32 partial product per step
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] mix_in;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mstep)
      MS_A_LL: begin
        mul_a = last_w[HALF_W-1:0];
        mul_b = GOLDEN_K[HALF_W-1:0];
      end
      MS_A_LH: begin
        mul_a = last_w[HALF_W-1:0];
        mul_b = GOLDEN_K[WORD_W-1:HALF_W];
      end
      MS_A_HL: begin
        mul_a = last_w[WORD_W-1:HALF_W];
        mul_b = GOLDEN_K[HALF_W-1:0];
      end
      MS_B_LL: begin
        mul_a = mix_r[HALF_W-1:0];
        mul_b = MIX_K[HALF_W-1:0];
      end
      MS_B_LH: begin
        mul_a = mix_r[HALF_W-1:0];
        mul_b = MIX_K[WORD_W-1:HALF_W];
      end
      MS_B_HL: begin
        mul_a = mix_r[WORD_W-1:HALF_W];
        mul_b = MIX_K[HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
  assign mix_in = first_w ^ acc_r ^ WORD_W'(name_cnt_r);

  // Accumulate partial products, fold the mix step, capture the time offset
  always_comb begin
    acc_nxt  = acc_r;
    mix_nxt  = mix_r;
    diff_nxt = diff_r;
    case (cmd.mstep)
      MS_A_LL: begin
        acc_nxt  = prod;
        diff_nxt = {1'b0, time_r} - {1'b0, base_units};
      end
      MS_B_LL: begin
        acc_nxt = prod;
      end
      MS_A_LH, MS_A_HL, MS_B_LH, MS_B_HL: begin
        acc_nxt = acc_r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      end
      MS_MIX: begin
        mix_nxt = mix_in ^ (mix_in >> MIX_SHIFT);
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // Month lookup: compare the offset against month start thresholds
  logic                 year_ok;
  logic [MONTH_W-1:0]   month_sel;

  assign year_ok = !diff_r[DIFF_W-1] && (diff_r[TIME_W-1:0] < YEAR_UNITS);

  always_comb begin
    month_sel = '0;
    for (int i = 1; i < MONTHS; i++) begin
      if (diff_r[TIME_W-1:0] >= TIME_W'(int'(MONTH_START[i]) * TICKS_PER_DAY)) begin
        month_sel = MONTH_W'(i);
      end
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TIME;
      digit_r    <= '0;
      time_r     <= '0;
      name_cnt_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      num_r      <= '0;
      len_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      digit_r    <= digit_nxt;
      time_r     <= time_nxt;
      name_cnt_r <= name_cnt_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      num_r      <= num_nxt;
      len_r      <= len_nxt;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    mix_r  <= mix_nxt;
    diff_r <= diff_nxt;
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_month_index    <= year_ok ? month_sel : '0;
      out_in_year        <= year_ok;
      out_name_length    <= name_cnt_r;
      out_first_bytes    <= first_w;
      out_last_bytes     <= last_w;
      out_hash_slot      <= HASH_SLOT_W'(acc_r[HALF_W +: SLOT_BITS]);
      out_message_length <= len_r;
      out_stamp_count    <= num_r;
    end
  end

endmodule

/* hw/rtl/csv_row_parse_fingerprint_top.sv */
// Top level of the CSV record parser: configuration register, controller and datapath.
// Depends on csvrpf_pkg, csvrpf_ctrl and csvrpf_dp.
//
// Takes one CSV line (timestamp,channel,length,stamps) a byte per transaction and
// emits one record at each newline that follows the stamps field; a newline earlier
// in the line drops it. Ordinary bytes are taken one per cycle. A record-ending
// newline holds in_stall high through ST_A_LL, ST_A_LH, ST_A_HL, ST_MIX, ST_B_LL,
// ST_B_LH, ST_B_HL and ST_DONE while one shared 32x32 multiplier forms the
// fingerprint in six partial products around a mix step, and the record is loaded
// into the output register; ST_DONE stretches for as long as the previous record is
// still held by out_stall. The next line can start while that record still waits
// on out_stall. The year start register sits at byte address 0 and should be
// written only while no line is in progress.
module csv_row_parse_fingerprint_top
  import csvrpf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_text_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MONTH_W-1:0]     out_month_index,
  output logic                   out_in_year,
  output logic [NAME_CNT_W-1:0]  out_name_length,
  output logic [WORD_W-1:0]      out_first_bytes,
  output logic [WORD_W-1:0]      out_last_bytes,
  output logic [HASH_SLOT_W-1:0] out_hash_slot,
  output logic [NUM_W-1:0]       out_message_length,
  output logic [NUM_W-1:0]       out_stamp_count
);

  logic [TIME_W-1:0] base_units_r;
  logic              reg_sel;
  dp_cmd_t           cmd;
  dp_status_t        status;

  // Register decode
  assign reg_sel = (paddr[2] == REG_BASE_UNITS);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CFG_DATA_W'(base_units_r) : '0;

  // Write the year start on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_units_r <= BASE_UNITS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      base_units_r <= pwdata[TIME_W-1:0];
    end
  end

  csvrpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  csvrpf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .base_units         (base_units_r),
    .in_text_byte       (in_text_byte),
    .out_month_index    (out_month_index),
    .out_in_year        (out_in_year),
    .out_name_length    (out_name_length),
    .out_first_bytes    (out_first_bytes),
    .out_last_bytes     (out_last_bytes),
    .out_hash_slot      (out_hash_slot),
    .out_message_length (out_message_length),
    .out_stamp_count    (out_stamp_count)
  );

endmodule

/* hw/rtl/csvrpf_chk.sv */
// Port-level checker for the CSV record parser, bound to the top level.
// Depends on csvrpf_pkg and csv_row_parse_fingerprint_top.
module csvrpf_chk
  import csvrpf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [MONTH_W-1:0]    out_month_index,
  input logic                  out_in_year,
  input logic [NAME_CNT_W-1:0] out_name_length,
  input logic [WORD_W-1:0]     out_first_bytes,
  input logic [WORD_W-1:0]     out_last_bytes
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Month is a real month, and zero outside the year
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_index <= MONTH_W'(MONTHS - 1)) &&
                  (out_in_year || (out_month_index == '0)))
    else $error("month index out of range");

  // Short names report the same window twice
  a_short_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_name_length < NAME_CNT_W'(WIN_BYTES)) |->
      (out_last_bytes == out_first_bytes))
    else $error("short name windows differ");

  // A new record only appears after the input was held for its finish
  a_new_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("record without end-of-line sequence");

endmodule

bind csv_row_parse_fingerprint_top csvrpf_chk u_chk (.*);
